### rtl/qbp_pkg.sv
// ----------------------------------------------------------------------------
// qbp_pkg: shared types and constants for the quantize and bit pack block
// Field widths, frame size, result codes, beat payloads and state encodings.
// ----------------------------------------------------------------------------
package qbp_pkg;

  // Frame size in bytes and the bit limit that follows from it
  localparam int FRAME_BYTES = 64;
  localparam int LIMIT_BITS  = FRAME_BYTES * 8;
  localparam int BC_W        = $clog2(LIMIT_BITS + 1);

  // Field widths
  localparam int ACT_W = 2;
  localparam int VAL_W = 32;
  localparam int CB_W  = 5;
  localparam int LEN_W = 7;
  localparam int STS_W = 2;

  // Adder width for bit count plus code length or pad
  localparam int SUM_W = ((BC_W > CB_W) ? BC_W : CB_W) + 1;

  // Divider remainder width: twice the range plus one guard bit
  localparam int DIV_W = VAL_W + 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_START  = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_FINISH = 2'd2
  } action_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK          = 2'd0,
    STS_ZERO_RES    = 2'd1,
    STS_EMPTY_RANGE = 2'd2,
    STS_OVERFLOW    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PK_IDLE,
    PK_RESP,
    PK_DIV
  } pk_state_e;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_CLAMP,
    DV_DIFF,
    DV_INIT,
    DV_RUN
  } dv_phase_e;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] lower_bound;
    logic signed [VAL_W-1:0] upper_bound;
    logic [CB_W-1:0]         code_bits;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             last;
    logic [LEN_W-1:0] frame_length;
    logic [STS_W-1:0] status;
  } out_beat_t;

  // Packer to divider control
  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

  // Divider to packer status
  typedef struct packed {
    logic            bit_valid;
    logic            q_bit;
    logic [CB_W-1:0] bits_left;
  } div_sts_t;

endpackage

### rtl/qbp_in_if.sv
// ----------------------------------------------------------------------------
// qbp_in_if: input channel of the quantize and bit pack block
// Valid/ready handshake carrying one command beat.
// ----------------------------------------------------------------------------
interface qbp_in_if;
  logic               valid;
  logic               ready;
  qbp_pkg::in_beat_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/qbp_out_if.sv
// ----------------------------------------------------------------------------
// qbp_out_if: output channel of the quantize and bit pack block
// Valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface qbp_out_if;
  logic               valid;
  logic               ready;
  qbp_pkg::out_beat_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/quantize_and_bit_pack_top.sv
// ----------------------------------------------------------------------------
// quantize_and_bit_pack_top: telemetry frame packer with linear quantizer
// Start, finish and rejected commands: one result beat, held in resp_q and then
// loaded into the output register; the next command is taken once it is loaded.
// Add: clamp, difference and init phases in the divider, then one code bit per
// cycle from the serial divider while no full byte stalls on a busy output; each
// full byte goes out as a beat, and an add that emits no byte ends with a result beat.
// One command in flight at a time; reset clears bit count and partial byte.
// ----------------------------------------------------------------------------
module quantize_and_bit_pack_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  qbp_in_if.sink     in_i,
  qbp_out_if.source  out_o
);

  qbp_pkg::pk_state_e state_q, state_d;

  logic [qbp_pkg::BC_W-1:0]  bc_q, bc_d;
  logic [7:0]                partial_q, partial_d, bit_partial;
  logic                      any_q, any_d;
  qbp_pkg::out_beat_t        resp_q, resp_d, out_q, out_beat;
  logic                      out_valid_q, out_load, slot_free;
  logic [qbp_pkg::SUM_W-1:0] add_sum, pad_sum;
  logic                      byte_done;
  qbp_pkg::div_ctl_t         div_ctl;
  qbp_pkg::div_sts_t         div_sts;

  qbp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .op_i   (in_i.payload),
    .sts_o  (div_sts)
  );

  assign slot_free = !out_valid_q || out_o.ready;
  assign add_sum   = qbp_pkg::SUM_W'(bc_q) + qbp_pkg::SUM_W'(in_i.payload.code_bits);
  assign pad_sum   = qbp_pkg::SUM_W'(bc_q) + qbp_pkg::SUM_W'(4'd8 - {1'b0, bc_q[2:0]});
  assign byte_done = (bc_q[2:0] == 3'd7);

  // Place the incoming code bit at the next free position
  always_comb begin
    bit_partial = partial_q;
    bit_partial[~bc_q[2:0]] = div_sts.q_bit;
  end

  assign in_i.ready = (state_q == qbp_pkg::PK_IDLE);

  // Command decode, bit append and result sequencing
  always_comb begin
    state_d  = state_q;
    bc_d     = bc_q;
    partial_d = partial_q;
    resp_d   = resp_q;
    any_d    = any_q;
    out_load = 1'b0;
    out_beat = '0;
    div_ctl  = '0;
    case (state_q)
      qbp_pkg::PK_IDLE: begin
        if (in_i.valid) begin
          state_d = qbp_pkg::PK_RESP;
          resp_d  = '0;
          resp_d.last = 1'b1;
          case (qbp_pkg::action_e'(in_i.payload.action))
            qbp_pkg::ACT_START: begin
              bc_d      = '0;
              partial_d = '0;
            end
            qbp_pkg::ACT_ADD: begin
              if (in_i.payload.code_bits == '0) begin
                resp_d.status = qbp_pkg::STS_ZERO_RES;
              end else if (in_i.payload.upper_bound <= in_i.payload.lower_bound) begin
                resp_d.status = qbp_pkg::STS_EMPTY_RANGE;
              end else if (add_sum > qbp_pkg::SUM_W'(qbp_pkg::LIMIT_BITS)) begin
                resp_d.status = qbp_pkg::STS_OVERFLOW;
              end else begin
                div_ctl.start = 1'b1;
                any_d   = 1'b0;
                state_d = qbp_pkg::PK_DIV;
              end
            end
            qbp_pkg::ACT_FINISH: begin
              if (pad_sum > qbp_pkg::SUM_W'(qbp_pkg::LIMIT_BITS)) begin
                resp_d.status       = qbp_pkg::STS_OVERFLOW;
                resp_d.frame_length = qbp_pkg::LEN_W'(bc_q >> 3);
              end else begin
                resp_d.out_byte     = partial_q;
                resp_d.byte_valid   = 1'b1;
                resp_d.frame_length = qbp_pkg::LEN_W'(pad_sum >> 3);
                bc_d      = qbp_pkg::BC_W'(pad_sum);
                partial_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      qbp_pkg::PK_RESP: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_beat = resp_q;
          state_d  = qbp_pkg::PK_IDLE;
        end
      end
      qbp_pkg::PK_DIV: begin
        if (div_sts.bit_valid && (!byte_done || slot_free)) begin
          div_ctl.step = 1'b1;
          bc_d = bc_q + qbp_pkg::BC_W'(1);
          if (byte_done) begin
            out_load            = 1'b1;
            out_beat.out_byte   = bit_partial;
            out_beat.byte_valid = 1'b1;
            out_beat.last       = (div_sts.bits_left < qbp_pkg::CB_W'(8));
            out_beat.status     = qbp_pkg::STS_OK;
            partial_d = '0;
            any_d     = 1'b1;
          end else begin
            partial_d = bit_partial;
          end
          if (div_sts.bits_left == '0) begin
            if (!byte_done && !any_q) begin
              resp_d      = '0;
              resp_d.last = 1'b1;
              state_d     = qbp_pkg::PK_RESP;
            end else begin
              state_d = qbp_pkg::PK_IDLE;
            end
          end
        end
      end
      default: state_d = qbp_pkg::PK_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qbp_pkg::PK_IDLE;
      bc_q        <= '0;
      partial_q   <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bc_q        <= bc_d;
      partial_q   <= partial_d;
      any_q       <= any_d;
      out_valid_q <= out_load || (out_valid_q && !out_o.ready);
    end
  end

  // Result payload registers
  always_ff @(posedge clk_i) begin
    resp_q <= resp_d;
    if (out_load) begin
      out_q <= out_beat;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // Bit count never passes the frame limit
  a_bc_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q <= qbp_pkg::BC_W'(qbp_pkg::LIMIT_BITS))
    else $error("qbp: bit count beyond frame");

  // Unfilled positions of the partial byte stay clear
  a_partial_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (partial_q & (8'hFF >> bc_q[2:0])) == 8'h00)
    else $error("qbp: stray bits in partial byte");

  // A completed byte lands in the output register
  a_byte_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qbp_pkg::PK_DIV && div_ctl.step && byte_done)
      |=> (out_valid_q && out_q.byte_valid))
    else $error("qbp: completed byte not presented");

endmodule

### rtl/qbp_div.sv
// ----------------------------------------------------------------------------
// qbp_div: bit-serial linear quantizer
// Clamps the sample, then runs a restoring division that yields the code
// one bit per step, most significant bit first.
// ----------------------------------------------------------------------------
module qbp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qbp_pkg::div_ctl_t  ctl_i,
  input  qbp_pkg::in_beat_t  op_i,
  output qbp_pkg::div_sts_t  sts_o
);

  // code = floor(N / D), N = 2*full*num + den, D = 2*den.
  // With e = den - 2*num: N = num*2^(r+1) + e, so N >> r = 2*num + (e >>> r)
  // and the low r bits of N are the low r bits of e.

  qbp_pkg::dv_phase_e phase_q, phase_d;

  logic signed [qbp_pkg::VAL_W-1:0] v_q, lo_q, hi_q, vc;
  logic [qbp_pkg::CB_W-1:0]         r_q, cnt_q;
  logic [qbp_pkg::VAL_W-1:0]        num_q, den_q, num_d, den_d;
  logic signed [qbp_pkg::DIV_W-1:0] e_q, e_d, e_sh;
  logic [qbp_pkg::DIV_W-1:0]        rem_q, rem_init, rem_next, trial, dsr;
  logic [qbp_pkg::VAL_W-1:0]        e_low;
  logic                             ge;

  // Clamp and range
  always_comb begin
    if (v_q < lo_q) begin
      vc = lo_q;
    end else if (v_q > hi_q) begin
      vc = hi_q;
    end else begin
      vc = v_q;
    end
  end

  assign num_d = vc - lo_q;
  assign den_d = hi_q - lo_q;
  assign e_d   = $signed({2'b00, den_q}) - $signed({1'b0, num_q, 1'b0});

  // Initial remainder and one restoring step
  assign e_sh     = e_q >>> r_q;
  assign rem_init = {1'b0, num_q, 1'b0} + $unsigned(e_sh);
  assign e_low    = e_q[qbp_pkg::VAL_W-1:0];
  assign dsr      = {1'b0, den_q, 1'b0};
  assign trial    = {rem_q[qbp_pkg::DIV_W-2:0], e_low[cnt_q]};
  assign ge       = (trial >= dsr);
  assign rem_next = ge ? (trial - dsr) : trial;

  assign sts_o.bit_valid = (phase_q == qbp_pkg::DV_RUN);
  assign sts_o.q_bit     = ge;
  assign sts_o.bits_left = cnt_q;

  // Phase sequencing
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      qbp_pkg::DV_IDLE:  phase_d = ctl_i.start ? qbp_pkg::DV_CLAMP : qbp_pkg::DV_IDLE;
      qbp_pkg::DV_CLAMP: phase_d = qbp_pkg::DV_DIFF;
      qbp_pkg::DV_DIFF:  phase_d = qbp_pkg::DV_INIT;
      qbp_pkg::DV_INIT:  phase_d = qbp_pkg::DV_RUN;
      qbp_pkg::DV_RUN: begin
        if (ctl_i.step && (cnt_q == '0)) begin
          phase_d = qbp_pkg::DV_IDLE;
        end
      end
      default: phase_d = qbp_pkg::DV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= qbp_pkg::DV_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  // Operand capture and datapath registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      v_q  <= op_i.value;
      lo_q <= op_i.lower_bound;
      hi_q <= op_i.upper_bound;
      r_q  <= op_i.code_bits;
    end
    case (phase_q)
      qbp_pkg::DV_CLAMP: begin
        num_q <= num_d;
        den_q <= den_d;
      end
      qbp_pkg::DV_DIFF: begin
        e_q <= e_d;
      end
      qbp_pkg::DV_INIT: begin
        rem_q <= rem_init;
        cnt_q <= r_q - qbp_pkg::CB_W'(1);
      end
      qbp_pkg::DV_RUN: begin
        if (ctl_i.step) begin
          rem_q <= rem_next;
          cnt_q <= cnt_q - qbp_pkg::CB_W'(1);
        end
      end
      default: ;
    endcase
  end

  // Remainder stays below the divisor through the whole run
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == qbp_pkg::DV_RUN) |-> (rem_q < dsr))
    else $error("qbp_div: remainder not below divisor");

  // Final step returns to idle
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == qbp_pkg::DV_RUN && ctl_i.step && cnt_q == '0)
      |=> (phase_q == qbp_pkg::DV_IDLE))
    else $error("qbp_div: run did not end after last bit");

  // Start from idle enters the clamp phase
  a_start_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == qbp_pkg::DV_IDLE && ctl_i.start) |=> (phase_q == qbp_pkg::DV_CLAMP))
    else $error("qbp_div: start not taken");

endmodule
